/* rtl/u8u16_pkg.sv */
// Package with the item types, decoder state and UTF-8/UTF-16 constants.
package u8u16_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
    localparam logic [20:0] CP_MIN_2BYTE  = 21'h000080;
    localparam logic [15:0] HIGH_SURR_TAG = 16'hD800;
    localparam logic [15:0] LOW_SURR_TAG  = 16'hDC00;
    localparam logic [9:0]  SURR_MASK     = 10'h3FF;

    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        status;
        logic        end_of_string;
    } out_item_t;

    typedef struct packed {
        logic [20:0] code_point_accumulator;
        logic [1:0]  bytes_remaining;
        logic [1:0]  sequence_length;
        logic        string_failed;
    } dec_state_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

/* rtl/utf8_to_utf16_validating_decoder.sv */
// Top level: UTF-8 byte stream in, validated UTF-16 code units out.
// A result passes through the result queue, so it is registered before it is shown.
// Throughput: one byte per cycle while the result queue has room for two items; a surrogate pair is two output items.
// Ready depends only on the fill level of the result queue, never on out_ready.
// Reset clears the sequence state, the failed-string flag and the result queue.
module utf8_to_utf16_validating_decoder
    import u8u16_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dec_state_t state_reg, state_next, step_state;
    push_t      step_push, push;
    logic       accept;
    logic       space_two;

    assign in_ready = space_two;
    assign accept   = in_valid && in_ready;

    u8u16_step u_step (
        .state      (state_reg),
        .item       (in_data),
        .state_next (step_state),
        .push       (step_push)
    );

    always_comb
    begin
        state_next = accept ? step_state : state_reg;
        push       = step_push;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    u8u16_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_two (space_two),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/u8u16_step.sv */
// Combinational decode of one UTF-8 byte against the current sequence state.
module u8u16_step
    import u8u16_pkg::*;
(
    input  dec_state_t state,
    input  in_item_t   item,
    output dec_state_t state_next,
    output push_t      push
);

    logic [7:0]  b;
    logic        last;
    logic [20:0] acc_cont;
    logic [19:0] cp_off;
    logic        bad_cp;

    always_comb
    begin
        b          = item.data_byte;
        last       = item.last_byte;
        acc_cont   = {state.code_point_accumulator[14:0], b[5:0]};
        cp_off     = 20'(acc_cont - CP_SUPP_BASE);
        bad_cp     = ((state.sequence_length == SEQ_TWO) && (acc_cont < CP_MIN_2BYTE))
                  || ((state.sequence_length == SEQ_THREE) && (acc_cont < CP_MIN_3BYTE))
                  || ((state.sequence_length == SEQ_FOUR) && (acc_cont < CP_SUPP_BASE))
                  || (acc_cont > CP_MAX)
                  || ((acc_cont >= CP_SURR_LO) && (acc_cont <= CP_SURR_HI));

        state_next  = state;
        push.count  = 2'd0;
        push.first  = '{code_unit: 16'h0, status: STATUS_INVALID, end_of_string: last};
        push.second = '{code_unit: 16'h0, status: STATUS_OK, end_of_string: last};

        if (state.string_failed)
        begin
            if (last)
            begin
                state_next.string_failed = 1'b0;
            end
        end
        else if (state.bytes_remaining == 2'd0)
        begin
            if (b[7] == 1'b0)
            begin
                push.count = 2'd1;
                push.first = '{code_unit: {8'h00, b}, status: STATUS_OK,
                               end_of_string: last};
            end
            else if ((b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
                     && !last)
            begin
                if (b[7:5] == 3'b110)
                begin
                    state_next.code_point_accumulator = {16'h0, b[4:0]};
                    state_next.sequence_length        = SEQ_TWO;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    state_next.code_point_accumulator = {17'h0, b[3:0]};
                    state_next.sequence_length        = SEQ_THREE;
                end
                else
                begin
                    state_next.code_point_accumulator = {18'h0, b[2:0]};
                    state_next.sequence_length        = SEQ_FOUR;
                end
                state_next.bytes_remaining = state_next.sequence_length;
            end
            else
            begin
                state_next = '{code_point_accumulator: 21'h0, bytes_remaining: 2'd0,
                               sequence_length: SEQ_NONE, string_failed: !last};
                push.count = 2'd1;
            end
        end
        else if ((b[7:6] != 2'b10)
                 || ((state.bytes_remaining != 2'd1) && last)
                 || ((state.bytes_remaining == 2'd1) && bad_cp))
        begin
            state_next = '{code_point_accumulator: 21'h0, bytes_remaining: 2'd0,
                           sequence_length: SEQ_NONE, string_failed: !last};
            push.count = 2'd1;
        end
        else if (state.bytes_remaining != 2'd1)
        begin
            state_next.code_point_accumulator = acc_cont;
            state_next.bytes_remaining        = state.bytes_remaining - 2'd1;
        end
        else
        begin
            state_next = '{code_point_accumulator: 21'h0, bytes_remaining: 2'd0,
                           sequence_length: SEQ_NONE, string_failed: 1'b0};
            if (acc_cont[20:16] == 5'd0)
            begin
                push.count = 2'd1;
                push.first = '{code_unit: acc_cont[15:0], status: STATUS_OK,
                               end_of_string: last};
            end
            else
            begin
                push.count  = 2'd2;
                push.first  = '{code_unit: HIGH_SURR_TAG | {6'h0, cp_off[19:10]},
                                status: STATUS_OK, end_of_string: 1'b0};
                push.second = '{code_unit: LOW_SURR_TAG | {6'h0, cp_off[9:0] & SURR_MASK},
                                status: STATUS_OK, end_of_string: last};
            end
        end
    end

endmodule

/* rtl/u8u16_fifo.sv */
// Result queue that takes up to two items per cycle and delivers one per cycle while out_ready is high.
module u8u16_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      space_two,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    out_item_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] wr_ptr_inc;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign space_two  = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

/* rtl/u8u16_checker.sv */
// Port-level checker for the decoder and its bind statement.
module u8u16_checker
    import u8u16_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic high_surr;
    logic low_surr;

    assign high_surr = (out_data.code_unit[15:10] == 6'b110110)
                    && (out_data.status == STATUS_OK);
    assign low_surr  = (out_data.code_unit[15:10] == 6'b110111)
                    && (out_data.status == STATUS_OK);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output item changed while stalled.");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_INVALID |-> out_data.code_unit == 16'h0)
        else $error("Invalid item carries a nonzero code unit.");

    a_high_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && high_surr |-> !out_data.end_of_string)
        else $error("High surrogate marked as end of string.");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && high_surr |=> out_valid && low_surr)
        else $error("High surrogate not followed at once by a low surrogate.");

endmodule

bind utf8_to_utf16_validating_decoder u8u16_checker u_checker (.*);
